@@ design/sem_pkg.sv @@
`default_nettype none
package sem_pkg;
   localparam int CFG_W  = 11;
   localparam int PIX_W  = 8;
   localparam int CH_N   = 3;
   localparam int DATA_W = PIX_W * CH_N;
   localparam int GRD_W  = 11;
   localparam int SQ_W   = 21;

   localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic [SQ_W-1:0]  MAG_SAT = 21'd65280;
   localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

   typedef struct packed {
      logic div_start;
      logic div_step;
      logic accept;
      logic mem_read;
      logic shift;
      logic grad;
      logic square;
      logic sqrt_step;
      logic round;
      logic load_out;
   } sem_cmd_type;

   typedef struct packed {
      logic div_done;
      logic sqrt_done;
      logic result_valid;
      logic out_free;
   } sem_stat_type;
endpackage
`default_nettype wire

@@ design/sobel_edge_magnitude_unit.sv @@
`default_nettype none
// Channel  Direction  Signals                              Carries
// req      in         req_tvalid/tready, tdata, tuser      one pixel or flush item
// rsp      out        rsp_tvalid/tready, tdata, tlast      one edge magnitude triple
// csr      in         csr_we, csr_index, csr_wdata         image width / height
//
// An item that yields no result is accepted, read and shifted into the window;
// one that yields a result goes on through gradient, square, eight root steps,
// round and output load. Any register write is followed by a position recompute
// before the next item, also once after reset. Reset is synchronous; the line
// stores are not cleared. A result waits in the output register while the next
// item is accepted; only a second pending result stalls the unit.
module sobel_edge_magnitude_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [sem_pkg::DATA_W-1:0]  req_tdata,  // red_in, green_in, blue_in
   input  wire logic                        req_tuser,  // opcode
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [sem_pkg::DATA_W-1:0]       rsp_tdata,  // red_edge, green_edge, blue_edge
   output logic                             rsp_tlast,
   input  wire logic                        csr_we,
   input  wire logic                        csr_index,
   input  wire logic [sem_pkg::CFG_W-1:0]   csr_wdata
);
   sem_pkg::sem_cmd_type  cmd;
   sem_pkg::sem_stat_type stat;

   sem_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sem_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .stat       (stat)
   );
endmodule
`default_nettype wire

@@ design/sem_ctrl.sv @@
`default_nettype none
module sem_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire sem_pkg::sem_stat_type stat,
   output sem_pkg::sem_cmd_type    cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_DIV, S_READ, S_SHIFT, S_GRAD, S_SQUARE, S_SQRT, S_ROUND, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      dirty_ff, dirty_in;

   assign req_tready = (state_ff == S_IDLE) && !dirty_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      dirty_in = dirty_ff | csr_we;
      unique case (state_ff)
         S_IDLE: begin
            if (dirty_ff) begin
               cmd.div_start = 1'b1;
               dirty_in      = csr_we;
               state_in      = S_DIV;
            end else if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_READ;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) state_in = S_IDLE;
         end
         S_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = S_SHIFT;
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            state_in  = stat.result_valid ? S_GRAD : S_IDLE;
         end
         S_GRAD: begin
            cmd.grad = 1'b1;
            state_in = S_SQUARE;
         end
         S_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (stat.sqrt_done) state_in = S_ROUND;
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dirty_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         dirty_ff <= dirty_in;
      end
   end
endmodule
`default_nettype wire

@@ design/sem_datapath.sv @@
`default_nettype none
module sem_datapath #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic                        csr_index,
   input  wire logic [sem_pkg::CFG_W-1:0]   csr_wdata,
   input  wire logic                        req_tuser,
   input  wire logic [sem_pkg::DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [sem_pkg::DATA_W-1:0]       rsp_tdata,
   output logic                             rsp_tlast,
   input  wire sem_pkg::sem_cmd_type        cmd,
   output sem_pkg::sem_stat_type            stat
);
   localparam int ADDR_W  = $clog2(MAX_WIDTH);
   localparam int WDIM_W  = $clog2(MAX_WIDTH + 1);
   localparam int HDIM_W  = $clog2(MAX_HEIGHT + 1);
   localparam int CNT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);
   localparam int DCNT_W  = $clog2(CNT_W + 1);
   localparam int PW      = sem_pkg::PIX_W;
   localparam int CH      = sem_pkg::CH_N;
   localparam int DW      = sem_pkg::DATA_W;
   localparam int GW      = sem_pkg::GRD_W;
   localparam int SW      = sem_pkg::SQ_W;

   logic [sem_pkg::CFG_W-1:0] wd_ff, ht_ff;
   logic [WDIM_W-1:0]         w_eff;
   logic [HDIM_W-1:0]         h_eff;

   logic [CNT_W-1:0]  frame_ff, total_ff, n_ff, r_ff, quo_ff;
   logic [ADDR_W-1:0] x_ff, addr_ff;
   logic [WDIM_W:0]   rem_ff, rem_shift, rem_next;
   logic              quo_bit;
   logic [DCNT_W-1:0] dcnt_ff;

   logic [DW-1:0]     upper_mem [MAX_WIDTH];
   logic [DW-1:0]     middle_mem [MAX_WIDTH];
   logic [DW-1:0]     up_rd_ff, mid_rd_ff, cur_ff;
   logic [DW-1:0]     win_ff [3][3];

   logic              valid_ff, last_ff;
   logic [3:0]        edge_ok_ff;
   logic [CNT_W-1:0]  prow;
   logic [ADDR_W-1:0] pcol;
   logic              top_ok, bot_ok, left_ok, right_ok;

   logic [GW-1:0]     ax_ff [CH];
   logic [GW-1:0]     ay_ff [CH];
   logic [SW-1:0]     s_ff [CH];
   logic [PW-1:0]     m_ff [CH];
   logic [PW-1:0]     mag_ff [CH];
   logic [PW-1:0]     bit_ff;

   logic              rsp_tvalid_ff, rsp_tlast_ff;
   logic [DW-1:0]     rsp_tdata_ff;

   always_comb begin
      if (wd_ff == '0) w_eff = WDIM_W'(1);
      else if (32'(wd_ff) > 32'(MAX_WIDTH)) w_eff = WDIM_W'(MAX_WIDTH);
      else w_eff = WDIM_W'(wd_ff);
      if (ht_ff == '0) h_eff = HDIM_W'(1);
      else if (32'(ht_ff) > 32'(MAX_HEIGHT)) h_eff = HDIM_W'(MAX_HEIGHT);
      else h_eff = HDIM_W'(ht_ff);
   end

   always_comb begin
      rem_shift = {rem_ff[WDIM_W-1:0], quo_ff[CNT_W-1]};
      quo_bit   = rem_shift >= (WDIM_W+1)'(w_eff);
      rem_next  = quo_bit ? rem_shift - (WDIM_W+1)'(w_eff) : rem_shift;
   end

   always_comb begin
      if (x_ff == '0) begin
         prow = r_ff - CNT_W'(2);
         pcol = ADDR_W'(w_eff - WDIM_W'(1));
      end else begin
         prow = r_ff - CNT_W'(1);
         pcol = x_ff - ADDR_W'(1);
      end
      top_ok   = prow != '0;
      bot_ok   = prow != CNT_W'(h_eff) - CNT_W'(1);
      left_ok  = pcol != '0;
      right_ok = WDIM_W'(pcol) != w_eff - WDIM_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wd_ff <= sem_pkg::CFG_RESET;
         ht_ff <= sem_pkg::CFG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            sem_pkg::CSR_WIDTH:  wd_ff <= csr_wdata;
            sem_pkg::CSR_HEIGHT: ht_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff    <= '0;
         x_ff    <= '0;
         r_ff    <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_start) begin
         frame_ff <= CNT_W'(w_eff) * CNT_W'(h_eff);
         total_ff <= CNT_W'(w_eff) * CNT_W'(h_eff) + CNT_W'(w_eff) + CNT_W'(1);
         quo_ff   <= n_ff;
         rem_ff   <= '0;
         dcnt_ff  <= '0;
      end else if (cmd.div_step) begin
         quo_ff  <= {quo_ff[CNT_W-2:0], quo_bit};
         rem_ff  <= rem_next;
         dcnt_ff <= dcnt_ff + DCNT_W'(1);
         if (stat.div_done) begin
            r_ff <= {quo_ff[CNT_W-2:0], quo_bit};
            x_ff <= ADDR_W'(rem_next);
         end
      end else if (cmd.accept) begin
         if (n_ff + CNT_W'(1) >= total_ff) begin
            n_ff <= '0;
            x_ff <= '0;
            r_ff <= '0;
         end else begin
            n_ff <= n_ff + CNT_W'(1);
            if (WDIM_W'(x_ff) + WDIM_W'(1) == w_eff) begin
               x_ff <= '0;
               r_ff <= r_ff + CNT_W'(1);
            end else begin
               x_ff <= x_ff + ADDR_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         addr_ff    <= x_ff;
         cur_ff     <= (req_tuser == sem_pkg::OP_PIXEL && n_ff < frame_ff) ? req_tdata : '0;
         valid_ff   <= (n_ff >= CNT_W'(w_eff) + CNT_W'(1)) && (n_ff < total_ff);
         edge_ok_ff <= {top_ok, bot_ok, left_ok, right_ok};
         last_ff    <= !bot_ok && !right_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         up_rd_ff  <= upper_mem[addr_ff];
         mid_rd_ff <= middle_mem[addr_ff];
      end
      if (cmd.shift) begin
         upper_mem[addr_ff]  <= mid_rd_ff;
         middle_mem[addr_ff] <= cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 3; m++) win_ff[k][m] <= '0;
         end
      end else if (cmd.shift) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k][0] <= win_ff[k][1];
            win_ff[k][1] <= win_ff[k][2];
         end
         win_ff[0][2] <= up_rd_ff;
         win_ff[1][2] <= mid_rd_ff;
         win_ff[2][2] <= cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.grad) begin
         for (int c = 0; c < CH; c++) begin
            logic signed [GW+1:0] gx, gy, hx, hy;
            logic        [2:0]    rok, cok;
            logic signed [GW+1:0] v [3][3];
            rok = {edge_ok_ff[2], 1'b1, edge_ok_ff[3]};
            cok = {edge_ok_ff[0], 1'b1, edge_ok_ff[1]};
            for (int k = 0; k < 3; k++) begin
               for (int m = 0; m < 3; m++) begin
                  v[k][m] = (rok[k] && cok[m]) ?
                            (GW+2)'({1'b0, win_ff[k][m][c*PW +: PW]}) : '0;
               end
            end
            gx = (v[0][2] - v[0][0]) + ((v[1][2] - v[1][0]) <<< 1) + (v[2][2] - v[2][0]);
            gy = (v[2][0] - v[0][0]) + ((v[2][1] - v[0][1]) <<< 1) + (v[2][2] - v[0][2]);
            hx = gx < 0 ? -gx : gx;
            hy = gy < 0 ? -gy : gy;
            ax_ff[c] <= GW'(hx);
            ay_ff[c] <= GW'(hy);
         end
      end
      if (cmd.square) begin
         for (int c = 0; c < CH; c++) begin
            s_ff[c] <= SW'(ax_ff[c]) * SW'(ax_ff[c]) + SW'(ay_ff[c]) * SW'(ay_ff[c]);
            m_ff[c] <= '0;
         end
         bit_ff <= {1'b1, {(PW-1){1'b0}}};
      end else if (cmd.sqrt_step) begin
         for (int c = 0; c < CH; c++) begin
            if (SW'(m_ff[c] | bit_ff) * SW'(m_ff[c] | bit_ff) <= s_ff[c])
               m_ff[c] <= m_ff[c] | bit_ff;
         end
         bit_ff <= bit_ff >> 1;
      end
      if (cmd.round) begin
         for (int c = 0; c < CH; c++) begin
            if (s_ff[c] > sem_pkg::MAG_SAT) mag_ff[c] <= sem_pkg::MAG_MAX;
            else if (s_ff[c] > SW'(m_ff[c]) * SW'(m_ff[c]) + SW'(m_ff[c]))
               mag_ff[c] <= m_ff[c] + PW'(1);
            else mag_ff[c] <= m_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         rsp_tdata_ff <= {mag_ff[2], mag_ff[1], mag_ff[0]};
         rsp_tlast_ff <= last_ff;
      end
   end

   assign stat.div_done     = dcnt_ff == DCNT_W'(CNT_W - 1);
   assign stat.sqrt_done    = bit_ff[0];
   assign stat.result_valid = valid_ff;
   assign stat.out_free     = !rsp_tvalid_ff || rsp_tready;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;
endmodule
`default_nettype wire

@@ design/sem_checker.sv @@
`default_nettype none
module sem_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_tvalid,
   input wire logic                       req_tready,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [sem_pkg::DATA_W-1:0] rsp_tdata,
   input wire logic                       csr_we
);
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready stayed high after a transaction");

   a_csr_recompute: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_tready)
      else $error("ready high right after a register write");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
endmodule

bind sobel_edge_magnitude_unit sem_checker u_sem_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_we     (csr_we)
);
`default_nettype wire

@@ test/tb.sv @@
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAXW = 1024;
   localparam int MAXH = 1024;
   localparam longint CYCLE_LIMIT = 64'd3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [sem_pkg::DATA_W-1:0] req_tdata = '0;
   logic req_tuser = sem_pkg::OP_PIXEL;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [sem_pkg::DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic csr_index = sem_pkg::CSR_WIDTH;
   logic [sem_pkg::CFG_W-1:0] csr_wdata = '0;

   sobel_edge_magnitude_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   typedef struct packed {
      logic [sem_pkg::PIX_W-1:0] red;
      logic [sem_pkg::PIX_W-1:0] green;
      logic [sem_pkg::PIX_W-1:0] blue;
      logic last;
   } edge_rec_type;

   edge_rec_type edges_due[$];
   logic [sem_pkg::CFG_W-1:0] width_reg = sem_pkg::CFG_RESET;
   logic [sem_pkg::CFG_W-1:0] height_reg = sem_pkg::CFG_RESET;
   logic [sem_pkg::DATA_W-1:0] upper_row [MAXW];
   logic [sem_pkg::DATA_W-1:0] middle_row [MAXW];
   logic [sem_pkg::DATA_W-1:0] win [3][3];
   int unsigned pos_count = 0;
   int mismatches = 0;
   longint cycles = 0;
   bit hold_rsp = 1'b0;
   int rsp_wait = 0;

   initial forever #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
      if (v < 1) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic logic [sem_pkg::PIX_W-1:0] root_round(int gx, int gy);
      int unsigned s, m, t;
      s = gx * gx + gy * gy;
      m = 0;
      if (s > sem_pkg::MAG_SAT) return sem_pkg::MAG_MAX;
      for (int b = 128; b != 0; b >>= 1) begin
         t = m | b;
         if (t * t <= s) m = t;
      end
      if (s > m * m + m) m++;
      return (m > 255) ? sem_pkg::MAG_MAX : m[sem_pkg::PIX_W-1:0];
   endfunction

   function automatic void predict_edges(logic op, logic [sem_pkg::DATA_W-1:0] pix);
      int unsigned w, h, frame, total, n, x, p;
      int row, col, r, c, gx, gy, v, sh;
      logic [sem_pkg::DATA_W-1:0] cur;
      edge_rec_type e;
      logic [sem_pkg::PIX_W-1:0] mag [3];
      int kx [3][3];
      int ky [3][3];
      kx = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
      ky = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};
      w = clamp_dim(width_reg, MAXW);
      h = clamp_dim(height_reg, MAXH);
      frame = w * h;
      total = frame + w + 1;
      n = pos_count;
      x = n % w;
      cur = (op == sem_pkg::OP_PIXEL && n < frame) ? pix : '0;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = upper_row[x];
      win[1][2] = middle_row[x];
      win[2][2] = cur;
      upper_row[x] = middle_row[x];
      middle_row[x] = cur;
      if (n >= w + 1 && n - w - 1 < frame) begin
         p = n - w - 1;
         row = p / w;
         col = p % w;
         for (int ch = 0; ch < 3; ch++) begin
            gx = 0;
            gy = 0;
            sh = 8 * ch;
            for (int k = 0; k < 3; k++) begin
               r = row + k - 1;
               if (r >= 0 && r < int'(h))
                  for (int m = 0; m < 3; m++) begin
                     c = col + m - 1;
                     if (c >= 0 && c < int'(w)) begin
                        v = (win[k][m] >> sh) & 8'hFF;
                        gx += v * kx[k][m];
                        gy += v * ky[k][m];
                     end
                  end
            end
            mag[ch] = root_round(gx, gy);
         end
         e.red = mag[0];
         e.green = mag[1];
         e.blue = mag[2];
         e.last = (p == frame - 1);
         edges_due.push_back(e);
      end
      n++;
      if (n >= total) n = 0;
      pos_count = n;
   endfunction

   function automatic int draw_gap();
      return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 18)) : 0;
   endfunction

   // receiver: drawn wait per transaction, long hold-off on request
   always @(posedge clock) begin
      if (reset || hold_rsp) begin
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_wait = draw_gap();
         rsp_tready <= (rsp_wait == 0);
      end else if (!rsp_tready) begin
         if (rsp_wait == 0) rsp_tready <= 1'b1;
         else rsp_wait--;
      end
   end

   always @(posedge clock) begin
      edge_rec_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (edges_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_tdata);
         end else begin
            want = edges_due.pop_front();
            if (rsp_tdata[7:0] !== want.red || rsp_tdata[15:8] !== want.green ||
                rsp_tdata[23:16] !== want.blue || rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: want %h %h %h last %b got %h %h %h last %b",
                           want.red, want.green, want.blue, want.last,
                           rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tlast);
            end
         end
      end
   end

   task automatic send_item(logic op, logic [sem_pkg::DATA_W-1:0] pix, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_edges(op, pix);
   endtask

   task automatic drain();
      int guard = 0;
      req_tvalid <= 1'b0;
      while (edges_due.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [sem_pkg::CFG_W-1:0] val);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == sem_pkg::CSR_WIDTH) width_reg = val;
      else height_reg = val;
   endtask

   task automatic run_frame(int noise_pct);
      int unsigned w, h, len;
      logic op;
      w = clamp_dim(width_reg, MAXW);
      h = clamp_dim(height_reg, MAXH);
      len = w * h + w + 1;
      for (int unsigned i = 0; i < len; i++) begin
         op = (i < w * h) ? sem_pkg::OP_PIXEL : sem_pkg::OP_FLUSH;
         if ($urandom_range(0, 99) < noise_pct) op = ~op;
         send_item(op, sem_pkg::DATA_W'($urandom), draw_gap());
      end
   endtask

   task automatic test_directed();
      write_reg(sem_pkg::CSR_WIDTH, 11'd3);
      write_reg(sem_pkg::CSR_HEIGHT, 11'd3);
      send_item(sem_pkg::OP_PIXEL, 24'hFFFFFF, 0);
      send_item(sem_pkg::OP_PIXEL, 24'h000000, 0);
      send_item(sem_pkg::OP_PIXEL, 24'hFFFFFF, 0);
      send_item(sem_pkg::OP_FLUSH, 24'hFFFFFF, 0);
      send_item(sem_pkg::OP_PIXEL, 24'hFF00FF, 0);
      send_item(sem_pkg::OP_PIXEL, 24'h00FF00, 0);
      send_item(sem_pkg::OP_PIXEL, 24'hFFFFFF, 1);
      send_item(sem_pkg::OP_PIXEL, 24'h123456, 0);
      send_item(sem_pkg::OP_PIXEL, 24'hFFFFFF, 2);
      send_item(sem_pkg::OP_PIXEL, 24'hABCDEF, 0);
      send_item(sem_pkg::OP_FLUSH, 24'h0, 0);
      send_item(sem_pkg::OP_FLUSH, 24'h0, 0);
      send_item(sem_pkg::OP_FLUSH, 24'h0, 0);
      write_reg(sem_pkg::CSR_WIDTH, 11'd0);
      write_reg(sem_pkg::CSR_HEIGHT, 11'd0);
      send_item(sem_pkg::OP_PIXEL, 24'hFFFFFF, 0);
      send_item(sem_pkg::OP_FLUSH, 24'h0, 0);
      send_item(sem_pkg::OP_FLUSH, 24'h0, 0);
   endtask

   task automatic test_odd_sizes();
      write_reg(sem_pkg::CSR_WIDTH, 11'd1);
      write_reg(sem_pkg::CSR_HEIGHT, 11'd7);
      run_frame(5);
      write_reg(sem_pkg::CSR_WIDTH, 11'd9);
      write_reg(sem_pkg::CSR_HEIGHT, 11'd1);
      run_frame(5);
   endtask

   task automatic test_random_frames();
      int items = 0;
      while (items < 700) begin
         write_reg(sem_pkg::CSR_WIDTH, sem_pkg::CFG_W'($urandom_range(1, 12)));
         write_reg(sem_pkg::CSR_HEIGHT, sem_pkg::CFG_W'($urandom_range(1, 10)));
         items += int'(clamp_dim(width_reg, MAXW) * clamp_dim(height_reg, MAXH)
                       + clamp_dim(width_reg, MAXW) + 1);
         run_frame(($urandom_range(0, 3) == 0) ? 10 : 0);
      end
   endtask

   task automatic test_backpressure();
      write_reg(sem_pkg::CSR_WIDTH, 11'd5);
      write_reg(sem_pkg::CSR_HEIGHT, 11'd4);
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (400) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         for (int i = 0; i < 26; i++)
            send_item(i < 20 ? sem_pkg::OP_PIXEL : sem_pkg::OP_FLUSH,
                      sem_pkg::DATA_W'($urandom), 0);
      join
   endtask

   task automatic test_wide_frame();
      write_reg(sem_pkg::CSR_WIDTH, 11'd2047);
      write_reg(sem_pkg::CSR_HEIGHT, 11'd2047);
      for (int i = 0; i < 40; i++)
         send_item(sem_pkg::OP_PIXEL, sem_pkg::DATA_W'($urandom), draw_gap());
      write_reg(sem_pkg::CSR_WIDTH, 11'd6);
      write_reg(sem_pkg::CSR_HEIGHT, 11'd5);
      do send_item(sem_pkg::OP_PIXEL, sem_pkg::DATA_W'($urandom), 0);
      while (pos_count != 0);
      run_frame(0);
      write_reg(sem_pkg::CSR_WIDTH, 11'd1);
      write_reg(sem_pkg::CSR_HEIGHT, 11'd2047);
      run_frame(0);
   endtask

   initial begin
      for (int i = 0; i < MAXW; i++) begin
         upper_row[i] = '0;
         middle_row[i] = '0;
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) win[i][j] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_odd_sizes();
      test_backpressure();
      test_random_frames();
      test_wide_frame();
      drain();
      if (mismatches == 0 && edges_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
